// File: hw/rtl/c0sc_pkg.sv
package c0sc_pkg;

    // Major opcode (fmt) field, bits 25:21
    localparam logic [4:0] FMT_MFC0 = 5'b00000;
    localparam logic [4:0] FMT_MTC0 = 5'b00100;
    localparam logic [4:0] FMT_BC0  = 5'b01000;
    localparam logic [4:0] FMT_TLB  = 5'b10000;

    // Function field of the TLB/CO group, bits 5:0
    localparam logic [5:0] FN_TLBR  = 6'b000001;
    localparam logic [5:0] FN_TLBWI = 6'b000010;
    localparam logic [5:0] FN_TLBWR = 6'b000110;
    localparam logic [5:0] FN_TLBP  = 6'b001000;
    localparam logic [5:0] FN_ERET  = 6'b011000;
    localparam logic [5:0] FN_EI    = 6'b111000;
    localparam logic [5:0] FN_DI    = 6'b111001;

    // COP0 register numbers
    localparam logic [4:0] R_INDEX    = 5'd0;
    localparam logic [4:0] R_ENTRYLO0 = 5'd2;
    localparam logic [4:0] R_ENTRYLO1 = 5'd3;
    localparam logic [4:0] R_PAGEMASK = 5'd5;
    localparam logic [4:0] R_ENTRYHI  = 5'd10;
    localparam logic [4:0] R_STATUS   = 5'd12;
    localparam logic [4:0] R_EPC      = 5'd14;
    localparam logic [4:0] R_ERROREPC = 5'd30;

    // Status register bit positions
    localparam int ST_EXL    = 1;
    localparam int ST_ERL    = 2;
    localparam int ST_KSU_LO = 3;
    localparam int ST_KSU_HI = 4;
    localparam int ST_EIE    = 16;
    localparam int ST_EDI    = 17;

    // TLB half-entry widths
    localparam int TLB_EVEN_W = 59;
    localparam int TLB_ODD_W  = 62;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_UNIMPL  = 2'd1,
        STAT_INVALID = 2'd2
    } t_status;

    // Decoded operation for one instruction
    typedef struct packed {
        logic    mfc0;
        logic    mtc0;
        logic    tlbwi;
        logic    eret;
        logic    eie_set;
        logic    eie_clr;
        t_status status;
    } t_dec;

endpackage

// File: hw/rtl/cop0_system_control_execute.sv
// COP0 execute block: one instruction per transfer, one result per instruction.
// Each instruction passes through the input register, then the result register,
// before its result is offered on o_valid.
// Throughput: one instruction per cycle, limited only by output backpressure.
// Reset clears the 32 COP0 registers and both valid flags; TLB contents are not reset.
module cop0_system_control_execute #(
    parameter int TLB_ENTRIES = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_instr,
    input  logic [31:0] i_rt_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_gpr_write,
    output logic [4:0]  o_gpr_index,
    output logic [31:0] o_gpr_data,
    output logic        o_pc_write,
    output logic [31:0] o_new_pc,
    output logic [1:0]  o_status_code
);

    localparam int TLB_AW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    // input stage
    logic        r_in_valid;
    logic [31:0] r_instr;
    logic [31:0] r_rt_value;

    // COP0 register file
    logic [31:0] r_cop0 [32];

    // result stage
    logic        r_out_valid;
    logic        r_gpr_write;
    logic [4:0]  r_gpr_index;
    logic [31:0] r_gpr_data;
    logic        r_pc_write;
    logic [31:0] r_new_pc;
    logic [1:0]  r_status_code;

    logic             advance;
    c0sc_pkg::t_dec   dec;
    logic [4:0]       rt;
    logic [4:0]       rd;
    logic [31:0]      status;
    logic             erl;
    logic             wr_en;
    logic [4:0]       wr_addr;
    logic [31:0]      wr_data;
    logic [5:0]       tlb_idx;
    logic             tlb_we;
    logic [TLB_AW-1:0] tlb_addr;
    logic [c0sc_pkg::TLB_EVEN_W-1:0] tlb_even;
    logic [c0sc_pkg::TLB_ODD_W-1:0]  tlb_odd;
    logic [31:0]      lo0;
    logic [31:0]      lo1;
    logic [31:0]      hi;

    // stage moves when result register is free or being drained
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_instr    <= i_instr;
            r_rt_value <= i_rt_value;
        end
    end

    assign rt     = r_instr[20:16];
    assign rd     = r_instr[15:11];
    assign status = r_cop0[c0sc_pkg::R_STATUS];
    assign erl    = status[c0sc_pkg::ST_ERL];

    c0sc_decode u_decode (
        .i_instr  (r_instr),
        .i_status (status),
        .o_dec    (dec)
    );

    // register file write: MTC0, or Status update by ERET/EI/DI
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = rd;
        wr_data = r_rt_value;
        if (dec.mtc0) begin
            wr_en = 1'b1;
        end else if (dec.eret) begin
            wr_en   = 1'b1;
            wr_addr = c0sc_pkg::R_STATUS;
            wr_data = status;
            if (erl) begin
                wr_data[c0sc_pkg::ST_ERL] = 1'b0;
            end else begin
                wr_data[c0sc_pkg::ST_EXL] = 1'b0;
            end
        end else if (dec.eie_set || dec.eie_clr) begin
            wr_en   = 1'b1;
            wr_addr = c0sc_pkg::R_STATUS;
            wr_data = status;
            wr_data[c0sc_pkg::ST_EIE] = dec.eie_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) begin
                r_cop0[i] <= '0;
            end
        end else if (advance && wr_en) begin
            r_cop0[wr_addr] <= wr_data;
        end
    end

    // TLBWI: pack EntryLo0/1, EntryHi, PageMask; out-of-range index is dropped
    assign lo0     = r_cop0[c0sc_pkg::R_ENTRYLO0];
    assign lo1     = r_cop0[c0sc_pkg::R_ENTRYLO1];
    assign hi      = r_cop0[c0sc_pkg::R_ENTRYHI];
    assign tlb_idx = r_cop0[c0sc_pkg::R_INDEX][5:0];
    assign tlb_we  = advance && dec.tlbwi && ({1'b0, tlb_idx} < 7'(TLB_ENTRIES));
    assign tlb_addr = TLB_AW'(tlb_idx);

    // even: global, vpn2, asid, scratchpad, pfn, cache, dirty, valid
    assign tlb_even = {lo0[0] & lo1[0], hi[31:13], hi[7:0], lo0[31:1]};
    // odd: page mask, pfn, cache, dirty, valid
    assign tlb_odd  = {r_cop0[c0sc_pkg::R_PAGEMASK], lo1[30:1]};

    c0sc_ram #(
        .WIDTH (c0sc_pkg::TLB_EVEN_W),
        .DEPTH (TLB_ENTRIES)
    ) u_tlb_even (
        .i_clk     (i_clk),
        .i_wr_en   (tlb_we),
        .i_wr_addr (tlb_addr),
        .i_wr_data (tlb_even),
        .i_rd_addr (tlb_addr),
        .o_rd_data ()
    );

    c0sc_ram #(
        .WIDTH (c0sc_pkg::TLB_ODD_W),
        .DEPTH (TLB_ENTRIES)
    ) u_tlb_odd (
        .i_clk     (i_clk),
        .i_wr_en   (tlb_we),
        .i_wr_addr (tlb_addr),
        .i_wr_data (tlb_odd),
        .i_rd_addr (tlb_addr),
        .o_rd_data ()
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_gpr_write   <= dec.mfc0;
            r_gpr_index   <= dec.mfc0 ? rt : 5'd0;
            r_gpr_data    <= dec.mfc0 ? r_cop0[rd] : 32'd0;
            r_pc_write    <= dec.eret;
            r_new_pc      <= !dec.eret ? 32'd0
                           : (erl ? r_cop0[c0sc_pkg::R_ERROREPC]
                                  : r_cop0[c0sc_pkg::R_EPC]);
            r_status_code <= dec.status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_gpr_write   = r_gpr_write;
    assign o_gpr_index   = r_gpr_index;
    assign o_gpr_data    = r_gpr_data;
    assign o_pc_write    = r_pc_write;
    assign o_new_pc      = r_new_pc;
    assign o_status_code = r_status_code;

    // a result never both writes a GPR and redirects the PC
    a_gpr_pc_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_gpr_write && o_pc_write))
        else $error("gpr write and pc write in one result");

    // a failing status carries no side outputs
    a_fail_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status_code != c0sc_pkg::STAT_DONE) |-> (!o_gpr_write && !o_pc_write))
        else $error("unimplemented/invalid op produced writes");

    // ERET always leaves ERL clear
    a_eret_erl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && dec.eret) |=> !r_cop0[c0sc_pkg::R_STATUS][c0sc_pkg::ST_ERL])
        else $error("ERL still set after ERET");

    // MTC0 lands in the addressed register
    a_mtc0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && dec.mtc0) |=> (r_cop0[$past(rd)] == $past(r_rt_value)))
        else $error("MTC0 data not written");

endmodule

// File: hw/rtl/c0sc_ram.sv
module c0sc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/c0sc_decode.sv
module c0sc_decode (
    input  logic [31:0]     i_instr,
    input  logic [31:0]     i_status,
    output c0sc_pkg::t_dec  o_dec
);

    logic [4:0] fmt;
    logic [5:0] fn;
    logic       eie_ok;

    assign fmt = i_instr[25:21];
    assign fn  = i_instr[5:0];

    // EI/DI allowed in exception/error level, kernel mode, or with EDI set
    assign eie_ok = i_status[c0sc_pkg::ST_EXL] | i_status[c0sc_pkg::ST_ERL]
                  | (i_status[c0sc_pkg::ST_KSU_HI:c0sc_pkg::ST_KSU_LO] == 2'b00)
                  | i_status[c0sc_pkg::ST_EDI];

    always_comb begin
        o_dec = '0;
        o_dec.status = c0sc_pkg::STAT_DONE;
        case (fmt)
            c0sc_pkg::FMT_MFC0: o_dec.mfc0 = 1'b1;
            c0sc_pkg::FMT_MTC0: o_dec.mtc0 = 1'b1;
            c0sc_pkg::FMT_BC0:  o_dec.status = c0sc_pkg::STAT_UNIMPL;
            c0sc_pkg::FMT_TLB: begin
                case (fn)
                    c0sc_pkg::FN_TLBR, c0sc_pkg::FN_TLBWR, c0sc_pkg::FN_TLBP: begin
                        o_dec.status = c0sc_pkg::STAT_UNIMPL;
                    end
                    c0sc_pkg::FN_TLBWI: o_dec.tlbwi = 1'b1;
                    c0sc_pkg::FN_ERET:  o_dec.eret = 1'b1;
                    c0sc_pkg::FN_EI:    o_dec.eie_set = eie_ok;
                    c0sc_pkg::FN_DI:    o_dec.eie_clr = eie_ok;
                    default:            o_dec.status = c0sc_pkg::STAT_INVALID;
                endcase
            end
            default: o_dec.status = c0sc_pkg::STAT_INVALID;
        endcase
    end

endmodule

// File: tb/cop0_system_control_execute_tb.sv
module cop0_system_control_execute_tb;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int STALL_CYCLES  = 300;
    localparam int DRAIN_CYCLES  = 10;
    localparam int RUN_LIMIT     = 12 * 200000;

    // One expected result of an executed COP0 instruction
    typedef struct {
        logic                 gpr_write;
        logic [4:0]           gpr_index;
        logic [31:0]          gpr_data;
        logic                 pc_write;
        logic [31:0]          new_pc;
        c0sc_pkg::t_status    status;
    } t_cop0_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_instr;
    logic [31:0] i_rt_value;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_gpr_write;
    logic [4:0]  o_gpr_index;
    logic [31:0] o_gpr_data;
    logic        o_pc_write;
    logic [31:0] o_new_pc;
    logic [1:0]  o_status_code;

    // Shadow copy of the coprocessor register file
    logic [31:0]  shadow_cop0 [32];
    t_cop0_result pending_results [$];

    int error_count  = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int stall_req    = 0;
    int stall_seen   = 0;
    int stall_left   = 0;

    cop0_system_control_execute uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_instr       (i_instr),
        .i_rt_value    (i_rt_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_gpr_write   (o_gpr_write),
        .o_gpr_index   (o_gpr_index),
        .o_gpr_data    (o_gpr_data),
        .o_pc_write    (o_pc_write),
        .o_new_pc      (o_new_pc),
        .o_status_code (o_status_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #RUN_LIMIT;
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Build an instruction word; unused bits are filled at random
    function automatic logic [31:0] cop0_word(logic [4:0] fmt, logic [4:0] rt,
                                              logic [4:0] rd, logic [5:0] fn);
        logic [31:0] w;
        w = $urandom;
        w[25:21] = fmt;
        w[20:16] = rt;
        w[15:11] = rd;
        w[5:0]   = fn;
        return w;
    endfunction

    function automatic logic eie_privileged(logic [31:0] st);
        return st[c0sc_pkg::ST_EXL] || st[c0sc_pkg::ST_ERL]
            || (st[c0sc_pkg::ST_KSU_HI:c0sc_pkg::ST_KSU_LO] == 2'b00)
            || st[c0sc_pkg::ST_EDI];
    endfunction

    // Execute one instruction on the shadow state and queue its result
    task automatic execute_cop0(logic [31:0] instr, logic [31:0] rtv);
        t_cop0_result res;
        logic [4:0]   fmt;
        logic [4:0]   rd;
        logic [5:0]   fn;
        logic [31:0]  st;
        fmt = instr[25:21];
        rd  = instr[15:11];
        fn  = instr[5:0];
        st  = shadow_cop0[c0sc_pkg::R_STATUS];
        res = '{1'b0, 5'd0, 32'd0, 1'b0, 32'd0, c0sc_pkg::STAT_DONE};
        case (fmt)
            c0sc_pkg::FMT_MFC0: begin
                res.gpr_write = 1'b1;
                res.gpr_index = instr[20:16];
                res.gpr_data  = shadow_cop0[rd];
            end
            c0sc_pkg::FMT_MTC0: shadow_cop0[rd] = rtv;
            c0sc_pkg::FMT_BC0:  res.status = c0sc_pkg::STAT_UNIMPL;
            c0sc_pkg::FMT_TLB: begin
                case (fn)
                    c0sc_pkg::FN_TLBR, c0sc_pkg::FN_TLBWR, c0sc_pkg::FN_TLBP:
                        res.status = c0sc_pkg::STAT_UNIMPL;
                    // TLB contents are never read back, so nothing to track
                    c0sc_pkg::FN_TLBWI: ;
                    c0sc_pkg::FN_ERET: begin
                        res.pc_write = 1'b1;
                        if (st[c0sc_pkg::ST_ERL]) begin
                            res.new_pc = shadow_cop0[c0sc_pkg::R_ERROREPC];
                            st[c0sc_pkg::ST_ERL] = 1'b0;
                        end else begin
                            res.new_pc = shadow_cop0[c0sc_pkg::R_EPC];
                            st[c0sc_pkg::ST_EXL] = 1'b0;
                        end
                        shadow_cop0[c0sc_pkg::R_STATUS] = st;
                    end
                    c0sc_pkg::FN_EI: if (eie_privileged(st))
                        shadow_cop0[c0sc_pkg::R_STATUS][c0sc_pkg::ST_EIE] = 1'b1;
                    c0sc_pkg::FN_DI: if (eie_privileged(st))
                        shadow_cop0[c0sc_pkg::R_STATUS][c0sc_pkg::ST_EIE] = 1'b0;
                    default: res.status = c0sc_pkg::STAT_INVALID;
                endcase
            end
            default: res.status = c0sc_pkg::STAT_INVALID;
        endcase
        pending_results.push_back(res);
    endtask

    // Offer one instruction and wait for its transfer
    task automatic send_instr(logic [31:0] instr, logic [31:0] rtv);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_instr    <= instr;
        i_rt_value <= rtv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        execute_cop0(instr, rtv);
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    task automatic check_result();
        t_cop0_result res;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %h",
                     $time, o_status_code);
            error_count++;
        end else begin
            res = pending_results.pop_front();
            report_field("gpr_write", 32'(res.gpr_write), 32'(o_gpr_write));
            report_field("gpr_index", 32'(res.gpr_index), 32'(o_gpr_index));
            report_field("gpr_data", res.gpr_data, o_gpr_data);
            report_field("pc_write", 32'(res.pc_write), 32'(o_pc_write));
            report_field("new_pc", res.new_pc, o_new_pc);
            report_field("status_code", 32'(res.status), 32'(o_status_code));
        end
    endtask

    // Result side: check each transfer, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) check_result();
        if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Extremes, each implemented operation and the special cases
    task automatic test_directed();
        send_instr(cop0_word(c0sc_pkg::FMT_MFC0, 5'd31, c0sc_pkg::R_STATUS, 6'd0),
                   32'hFFFF_FFFF);
        // index out of range, including upper bits set
        send_instr(cop0_word(c0sc_pkg::FMT_MTC0, 5'd0, c0sc_pkg::R_INDEX, 6'd0),
                   32'hFFFF_FFFF);
        send_instr(cop0_word(c0sc_pkg::FMT_TLB, 5'd0, 5'd0, c0sc_pkg::FN_TLBWI), 32'd0);
        send_instr(cop0_word(c0sc_pkg::FMT_MTC0, 5'd1, c0sc_pkg::R_INDEX, 6'd0), 32'd48);
        send_instr(cop0_word(c0sc_pkg::FMT_TLB, 5'd0, 5'd0, c0sc_pkg::FN_TLBWI), 32'd0);
        // last valid entry, scratchpad from EntryLo0 and the global AND
        send_instr(cop0_word(c0sc_pkg::FMT_MTC0, 5'd2, c0sc_pkg::R_INDEX, 6'd0), 32'd47);
        send_instr(cop0_word(c0sc_pkg::FMT_MTC0, 5'd3, c0sc_pkg::R_ENTRYLO0, 6'd0),
                   32'h8000_0001);
        send_instr(cop0_word(c0sc_pkg::FMT_MTC0, 5'd4, c0sc_pkg::R_ENTRYLO1, 6'd0),
                   32'h7FFF_FFFE);
        send_instr(cop0_word(c0sc_pkg::FMT_MTC0, 5'd5, c0sc_pkg::R_PAGEMASK, 6'd0),
                   32'hFFFF_FFFF);
        send_instr(cop0_word(c0sc_pkg::FMT_MTC0, 5'd6, c0sc_pkg::R_ENTRYHI, 6'd0),
                   32'hFFFF_FFFF);
        send_instr(cop0_word(c0sc_pkg::FMT_TLB, 5'd0, 5'd0, c0sc_pkg::FN_TLBWI), 32'd0);
        // ERET: ErrorEPC first while ERL is set, then EPC
        send_instr(cop0_word(c0sc_pkg::FMT_MTC0, 5'd7, c0sc_pkg::R_EPC, 6'd0),
                   32'hBFC0_0180);
        send_instr(cop0_word(c0sc_pkg::FMT_MTC0, 5'd8, c0sc_pkg::R_ERROREPC, 6'd0),
                   32'h8000_0000);
        send_instr(cop0_word(c0sc_pkg::FMT_MTC0, 5'd9, c0sc_pkg::R_STATUS, 6'd0),
                   32'h0000_0006);
        send_instr(cop0_word(c0sc_pkg::FMT_TLB, 5'd0, 5'd0, c0sc_pkg::FN_ERET), 32'd0);
        send_instr(cop0_word(c0sc_pkg::FMT_TLB, 5'd0, 5'd0, c0sc_pkg::FN_ERET), 32'd0);
        // EI without privilege, then EI/DI with EDI set
        send_instr(cop0_word(c0sc_pkg::FMT_MTC0, 5'd10, c0sc_pkg::R_STATUS, 6'd0),
                   32'h0000_0010);
        send_instr(cop0_word(c0sc_pkg::FMT_TLB, 5'd0, 5'd0, c0sc_pkg::FN_EI), 32'd0);
        send_instr(cop0_word(c0sc_pkg::FMT_MTC0, 5'd11, c0sc_pkg::R_STATUS, 6'd0),
                   32'h0002_0018);
        send_instr(cop0_word(c0sc_pkg::FMT_TLB, 5'd0, 5'd0, c0sc_pkg::FN_EI), 32'd0);
        send_instr(cop0_word(c0sc_pkg::FMT_MFC0, 5'd12, c0sc_pkg::R_STATUS, 6'd0), 32'd0);
        send_instr(cop0_word(c0sc_pkg::FMT_TLB, 5'd0, 5'd0, c0sc_pkg::FN_DI), 32'd0);
        // unimplemented and invalid encodings
        send_instr(cop0_word(c0sc_pkg::FMT_BC0, 5'd0, 5'd0, 6'h3F), 32'd0);
        send_instr(cop0_word(c0sc_pkg::FMT_TLB, 5'd0, 5'd0, c0sc_pkg::FN_TLBP), 32'd0);
        send_instr(cop0_word(5'b11111, 5'd0, 5'd0, 6'd0), 32'd0);
        send_instr(cop0_word(c0sc_pkg::FMT_TLB, 5'd0, 5'd0, 6'h3F), 32'd0);
    endtask

    // Mostly well-formed instructions with random operands
    task automatic test_random(int count);
        logic [31:0] instr;
        logic [31:0] rtv;
        logic [4:0]  rd;
        logic [4:0]  special [8];
        int          pick;
        special = '{c0sc_pkg::R_INDEX, c0sc_pkg::R_ENTRYLO0, c0sc_pkg::R_ENTRYLO1,
                    c0sc_pkg::R_PAGEMASK, c0sc_pkg::R_ENTRYHI, c0sc_pkg::R_STATUS,
                    c0sc_pkg::R_EPC, c0sc_pkg::R_ERROREPC};
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            rd   = ($urandom_range(1) != 0) ? special[$urandom_range(7)] : 5'($urandom);
            case ($urandom_range(9))
                0:       rtv = 32'd0;
                1:       rtv = 32'hFFFF_FFFF;
                default: rtv = $urandom;
            endcase
            if (pick < 20) begin
                instr = cop0_word(c0sc_pkg::FMT_MFC0, 5'($urandom), rd, 6'($urandom));
            end else if (pick < 45) begin
                instr = cop0_word(c0sc_pkg::FMT_MTC0, 5'($urandom), rd, 6'($urandom));
            end else if (pick < 53) begin
                instr = cop0_word(c0sc_pkg::FMT_TLB, 5'($urandom), 5'($urandom),
                                  c0sc_pkg::FN_TLBWI);
            end else if (pick < 62) begin
                instr = cop0_word(c0sc_pkg::FMT_TLB, 5'($urandom), 5'($urandom),
                                  c0sc_pkg::FN_ERET);
            end else if (pick < 72) begin
                instr = cop0_word(c0sc_pkg::FMT_TLB, 5'($urandom), 5'($urandom),
                                  ($urandom_range(1) != 0) ? c0sc_pkg::FN_EI
                                                           : c0sc_pkg::FN_DI);
            end else if (pick < 77) begin
                case ($urandom_range(3))
                    0: instr = cop0_word(c0sc_pkg::FMT_BC0, 5'($urandom), 5'($urandom),
                                         6'($urandom));
                    1: instr = cop0_word(c0sc_pkg::FMT_TLB, 5'($urandom), 5'($urandom),
                                         c0sc_pkg::FN_TLBR);
                    2: instr = cop0_word(c0sc_pkg::FMT_TLB, 5'($urandom), 5'($urandom),
                                         c0sc_pkg::FN_TLBWR);
                    default: instr = cop0_word(c0sc_pkg::FMT_TLB, 5'($urandom),
                                               5'($urandom), c0sc_pkg::FN_TLBP);
                endcase
            end else if (pick < 85) begin
                instr = cop0_word(c0sc_pkg::FMT_TLB, 5'($urandom), 5'($urandom),
                                  6'($urandom));
            end else begin
                instr = $urandom;
            end
            send_instr(instr, rtv);
        end
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        stall_req <= stall_req + 1;
        tx_idle_pct = 0;
        test_random(40);
    endtask

    initial begin
        for (int r = 0; r < 32; r++) shadow_cop0[r] = 32'd0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_instr    <= 32'd0;
        i_rt_value <= 32'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 35;
        rx_idle_pct <= 82;
        test_directed();
        test_random(600);

        tx_idle_pct = 82;
        rx_idle_pct <= 35;
        test_random(600);

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        test_random(600);

        test_backpressure();

        i_valid <= 1'b0;
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
